>>> hdl/idrp_pkg.sv
`timescale 1ns / 1ps

package idrp_pkg;

	localparam int OUT_TDATA_W = 184;

	localparam logic [8:0] FIXED_LEN = 9'd33;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_EXT_ATTR = 2'd2;
	localparam logic [1:0] ST_SHORT    = 2'd3;

	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_ID  = 2'd1;
	localparam logic [1:0] KIND_SU  = 2'd2;
	localparam logic [1:0] KIND_PAD = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_extent;
	} item_t;

	typedef struct packed {
		logic [31:0] extent_location;
		logic [31:0] data_length;
		logic [55:0] recording_time;
		logic [7:0]  file_flags;
		logic [7:0]  file_unit_size;
		logic [7:0]  interleave_gap;
		logic [15:0] volume_sequence;
		logic [7:0]  identifier_length;
		logic [1:0]  status;
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic        last_of_record;
	} result_t;

endpackage

>>> hdl/idrp_in_reg.sv
`timescale 1ns / 1ps

module idrp_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  idrp_pkg::item_t in_item,
	input  logic            advance,
	output logic            valid_s1,
	output idrp_pkg::item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> hdl/idrp_parser.sv
`timescale 1ns / 1ps

module idrp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  idrp_pkg::item_t   item,
	output logic              emit,
	output idrp_pkg::result_t result
);

	localparam logic [1:0] PH_LEN = 2'd0;
	localparam logic [1:0] PH_HDR = 2'd1;
	localparam logic [1:0] PH_PAY = 2'd2;

	logic [1:0]  phase_q, phase_d;
	logic [7:0]  cnt_q, cnt_d;
	logic        stop_q, stop_d;
	logic [7:0]  rlen_q, rlen_d;
	logic [7:0]  idlen_q, idlen_d;
	logic [63:0] be_q, be_d;
	logic        mis_q, mis_d;
	logic [63:0] hdr_q, hdr_d;
	logic [7:0]  unit_q, unit_d;
	logic [7:0]  gap_q, gap_d;
	logic [15:0] vseq_q, vseq_d;
	logic [1:0]  hst_q, hst_d;

	always_comb begin
		logic [1:0] ph;
		logic       stp;
		logic [7:0] b;
		logic [7:0] idx;
		logic [2:0] lane;
		logic       pad;
		logic [8:0] need;
		logic [8:0] idend;
		logic [1:0] st;
		logic [1:0] kd;
		logic [7:0] pl;
		logic       lst;

		phase_d = phase_q;
		cnt_d   = cnt_q;
		stop_d  = stop_q;
		rlen_d  = rlen_q;
		idlen_d = idlen_q;
		be_d    = be_q;
		mis_d   = mis_q;
		hdr_d   = hdr_q;
		unit_d  = unit_q;
		gap_d   = gap_q;
		vseq_d  = vseq_q;
		hst_d   = hst_q;
		emit    = 1'b0;
		st      = idrp_pkg::ST_OK;
		kd      = idrp_pkg::KIND_HDR;
		pl      = 8'd0;
		lst     = 1'b0;
		b       = item.data_byte;
		idx     = cnt_q;
		lane    = 3'd0;
		pad     = 1'b0;
		need    = 9'd0;
		idend   = 9'd0;
		ph      = phase_q;
		stp     = stop_q;

		if (fire) begin
			if (item.start_of_extent) begin
				ph      = PH_LEN;
				stp     = 1'b0;
				phase_d = PH_LEN;
				stop_d  = 1'b0;
				cnt_d   = 8'd0;
			end
			if (!stp) begin
				if (ph == PH_LEN) begin
					if (b != 8'd0) begin
						rlen_d  = b;
						idlen_d = 8'd0;
						be_d    = 64'd0;
						mis_d   = 1'b0;
						hdr_d   = 64'd0;
						unit_d  = 8'd0;
						gap_d   = 8'd0;
						vseq_d  = 16'd0;
						hst_d   = idrp_pkg::ST_OK;
						cnt_d   = 8'd1;
						phase_d = PH_HDR;
					end
				end else begin
					idx   = cnt_q;
					cnt_d = cnt_q + 8'd1;
					if (ph == PH_HDR) begin
						if (idx == 8'd1) begin
							if (b != 8'd0) begin
								emit    = 1'b1;
								st      = idrp_pkg::ST_EXT_ATTR;
								lst     = 1'b1;
								stop_d  = 1'b1;
								phase_d = PH_LEN;
							end
						end else if (idx >= 8'd2 && idx <= 8'd5) begin
							lane = 3'(idx - 8'd2);
							be_d[{lane, 3'b000} +: 8] = b;
						end else if (idx >= 8'd6 && idx <= 8'd9) begin
							lane  = 3'(8'd9 - idx);
							mis_d = mis_q | (be_q[{lane, 3'b000} +: 8] != b);
						end else if (idx >= 8'd10 && idx <= 8'd13) begin
							lane = 3'(idx - 8'd6);
							be_d[{lane, 3'b000} +: 8] = b;
						end else if (idx >= 8'd14 && idx <= 8'd17) begin
							lane  = 3'(8'd21 - idx);
							mis_d = mis_q | (be_q[{lane, 3'b000} +: 8] != b);
						end else if (idx >= 8'd18 && idx <= 8'd24) begin
							hdr_d[55:0] = {hdr_q[47:0], b};
						end else if (idx == 8'd25) begin
							hdr_d[63:56] = b;
						end else if (idx == 8'd26) begin
							unit_d = b;
						end else if (idx == 8'd27) begin
							gap_d = b;
						end else if (idx == 8'd28 || idx == 8'd29) begin
							vseq_d[{idx[0], 3'b000} +: 8] = b;
						end else if (idx == 8'd30 || idx == 8'd31) begin
							mis_d = mis_q | (vseq_q[{~idx[0], 3'b000} +: 8] != b);
						end else if (idx == 8'd32) begin
							pad     = ~b[0];
							need    = idrp_pkg::FIXED_LEN + {1'b0, b} + {8'd0, pad};
							idlen_d = b;
							emit    = 1'b1;
							if (need > {1'b0, rlen_q}) begin
								st      = idrp_pkg::ST_SHORT;
								lst     = 1'b1;
								stop_d  = 1'b1;
								phase_d = PH_LEN;
							end else begin
								hst_d   = mis_q ? idrp_pkg::ST_MISMATCH : idrp_pkg::ST_OK;
								st      = hst_d;
								phase_d = PH_PAY;
							end
						end
					end else begin
						idend = idrp_pkg::FIXED_LEN + {1'b0, idlen_q};
						pad   = ~idlen_q[0];
						if ({1'b0, idx} < idend) begin
							kd = idrp_pkg::KIND_ID;
						end else if (pad && ({1'b0, idx} == idend)) begin
							kd = idrp_pkg::KIND_PAD;
						end else begin
							kd = idrp_pkg::KIND_SU;
						end
						lst  = ({1'b0, idx} + 9'd1) >= {1'b0, rlen_q};
						if (lst) begin
							phase_d = PH_LEN;
						end
						emit = 1'b1;
						st   = hst_q;
						pl   = b;
					end
				end
			end
		end

		result.extent_location   = be_d[31:0];
		result.data_length       = be_d[63:32];
		result.recording_time    = hdr_d[55:0];
		result.file_flags        = hdr_d[63:56];
		result.file_unit_size    = unit_d;
		result.interleave_gap    = gap_d;
		result.volume_sequence   = vseq_d;
		result.identifier_length = idlen_d;
		result.status            = st;
		result.kind              = kd;
		result.payload_byte      = pl;
		result.last_of_record    = lst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			cnt_q   <= 8'd0;
			stop_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			stop_q  <= stop_d;
		end
	end

	always_ff @(posedge clk) begin
		rlen_q  <= rlen_d;
		idlen_q <= idlen_d;
		be_q    <= be_d;
		mis_q   <= mis_d;
		hdr_q   <= hdr_d;
		unit_q  <= unit_d;
		gap_q   <= gap_d;
		vseq_q  <= vseq_d;
		hst_q   <= hst_d;
	end

endmodule

>>> hdl/iso9660_directory_record_parser_core.sv
`timescale 1ns / 1ps

// Parses the directory records of an ISO 9660 extent fed one byte per transfer,
// with s_tuser marking the first byte of an extent. The block takes one byte
// every cycle while m_tready is high. A taken byte is held in the input register
// while the record state update computes the result, which is then loaded into
// the result register and offered on the master side. Each record yields one
// header result (m_tuser zero) when its identifier length byte arrives, then one
// result per identifier, pad and system-use byte, with m_tlast on the final
// byte. An extended attribute error or a record too short for its identifier
// ends the record with m_tlast and stops parsing until the next start of
// extent.
module iso9660_directory_record_parser_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// data_byte
	input  logic [7:0]                       s_tdata,
	// start_of_extent
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// extent_location, data_length, recording_time, file_flags, file_unit_size,
	// interleave_gap, volume_sequence, identifier_length, status, payload_byte
	output logic [idrp_pkg::OUT_TDATA_W-1:0] m_tdata,
	// kind
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast
);

	idrp_pkg::item_t   in_item;
	idrp_pkg::item_t   item_s1;
	idrp_pkg::result_t res_d;
	idrp_pkg::result_t res_q;
	logic              valid_s1;
	logic              advance;
	logic              fire;
	logic              emit;
	logic              out_valid_q;

	assign in_item.data_byte       = s_tdata;
	assign in_item.start_of_extent = s_tuser;

	assign advance = !out_valid_q || m_tready;
	assign fire    = valid_s1 && advance;

	idrp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	idrp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.emit   (emit),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last_of_record;
	assign m_tdata  = {6'd0,
		res_q.payload_byte,
		res_q.status,
		res_q.identifier_length,
		res_q.volume_sequence,
		res_q.interleave_gap,
		res_q.file_unit_size,
		res_q.file_flags,
		res_q.recording_time,
		res_q.data_length,
		res_q.extent_location};

endmodule
